// ----- sv/assert_macros.svh -----
// Assertion macros shared by the CRC key hash RTL.
// Needs no other file; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Implication checked in the next cycle, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- sv/crckh_pkg.sv -----
// Package for the CRC-32 key hash index block: constants and byte fold.
// No dependencies.
`default_nettype none

package crckh_pkg;

  localparam int unsigned CRC_W  = 32;
  localparam int unsigned BYTE_W = 8;

  localparam logic [CRC_W-1:0] GEN_POLY        = 32'h04C1_1DB7;
  localparam logic [CRC_W-1:0] HASH_MASK_RESET = 32'h0000_00FF;

  // Fold one byte into the CRC, MSB first, no reflection, no table.
  function automatic logic [CRC_W-1:0] fold_byte(input logic [CRC_W-1:0] acc,
                                                 input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] r;
    r = acc ^ {b, {(CRC_W-BYTE_W){1'b0}}};
    for (int k = 0; k < BYTE_W; k++) begin
      if (r[CRC_W-1]) begin
        r = {r[CRC_W-2:0], 1'b0} ^ GEN_POLY;
      end else begin
        r = {r[CRC_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/crckh_ifs.sv -----
// Valid/ready channel interfaces of the CRC key hash block.
// Depends on crckh_pkg for widths.
`default_nettype none

// Key byte channel: one key byte per item.
interface crckh_key_if;
  logic                             valid;
  logic                             ready;
  logic [crckh_pkg::BYTE_W-1:0]     key_byte;
  logic                             last_byte;
  modport source (output valid, output key_byte, output last_byte, input ready);
  modport sink   (input valid, input key_byte, input last_byte, output ready);
endinterface

// Hash result channel: one bucket index per key.
interface crckh_hash_if;
  logic                             valid;
  logic                             ready;
  logic [crckh_pkg::CRC_W-1:0]      hash_value;
  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

// Mask register write channel.
interface crckh_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [crckh_pkg::CRC_W-1:0]      data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/crc32_key_hash_index_core.sv -----
// Top level of the CRC-32 key hash index block.
// Depends on crckh_pkg, crckh_ifs.sv and assert_macros.svh.
// Takes one key byte per item, one item per clock when ready: the byte-wide CRC
// fold (polynomial 0x04C11DB7, MSB first, zero init, no final XOR) is
// combinational between the running CRC and result registers. On the last byte
// of a key the CRC ANDed with hash_mask is registered as the result, valid in
// the cycle after the item is taken; the running CRC restarts from zero. The
// result register holds until taken; a new byte is taken whenever that register
// is empty or is being emptied in the same cycle. Mask writes are always taken.
`default_nettype none

`include "assert_macros.svh"

module crc32_key_hash_index_core (
  input  wire logic         clk,
  input  wire logic         rst,
  crckh_key_if.sink         key,
  crckh_hash_if.source      hash,
  crckh_cfg_if.sink         cfg
);

  logic [crckh_pkg::CRC_W-1:0] running_crc;
  logic [crckh_pkg::CRC_W-1:0] hash_mask;
  logic [crckh_pkg::CRC_W-1:0] hash_value;
  logic                        out_valid;
  logic [crckh_pkg::CRC_W-1:0] crc_next;
  logic                        key_take;
  logic                        cfg_take;

  // Handshake: result register empty or draining this cycle.
  assign key.ready  = !out_valid || hash.ready;
  assign key_take   = key.valid && key.ready;
  assign cfg.ready  = 1'b1;
  assign cfg_take   = cfg.valid;

  // Byte-wide CRC update.
  assign crc_next = crckh_pkg::fold_byte(running_crc, key.key_byte);

  // Running CRC and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (hash.ready) begin
        out_valid <= 1'b0;
      end
      if (key_take) begin
        if (key.last_byte) begin
          running_crc <= '0;
          out_valid   <= 1'b1;
        end else begin
          running_crc <= crc_next;
        end
      end
    end
  end

  // Result payload, loaded on a last byte.
  always_ff @(posedge clk) begin
    if (key_take && key.last_byte) begin
      hash_value <= crc_next & hash_mask;
    end
  end

  // Mask register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_mask <= crckh_pkg::HASH_MASK_RESET;
    end else if (cfg_take) begin
      hash_mask <= cfg.data;
    end
  end

  assign hash.valid      = out_valid;
  assign hash.hash_value = hash_value;

  // Checks.
  `ASSERT_NEXT(a_crc_clear, clk, rst, key_take && key.last_byte, running_crc == '0)
  `ASSERT_NEXT(a_result_up, clk, rst, key_take && key.last_byte, out_valid)
  `ASSERT_NEXT(a_no_spurious, clk, rst, !out_valid && !(key_take && key.last_byte),
               !out_valid)
  `ASSERT_NEXT(a_mask_write, clk, rst, cfg_take, hash_mask == $past(cfg.data))
  `ASSERT_CLK(a_ready_free, clk, rst, !out_valid |-> key.ready)

endmodule

`default_nettype wire
